@@ rtl/assert_macros.svh @@
// assertion macros used by bounded_task_priority_queue
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
    `ASSERT_CLK(lbl, !(cond), msg)

`endif

@@ rtl/btpq_pkg.sv @@
// types and constants of the task priority queue
`timescale 1ns / 1ps
`default_nettype none

package btpq_pkg;

    localparam int TASK_W = 3;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_TASKS = 6;
    localparam logic [2:0] TASK_LIMIT = 3'd6;

    localparam logic [1:0] MODE_ADD  = 2'd0;
    localparam logic [1:0] MODE_SORT = 2'd1;
    localparam logic [1:0] MODE_POP  = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NO_TASK = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIO_FIRST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIO_LAST  = 3'd6;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SHIFT,
        CELL_SORT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     phase;
    } t_cell_cmd;

endpackage

`default_nettype wire

@@ rtl/btpq_cmd_if.sv @@
// command channel: operation mode and task index
`timescale 1ns / 1ps
`default_nettype none

interface btpq_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [btpq_pkg::TASK_W-1:0] task_index;

    modport source (output valid, output mode, output task_index, input ready);
    modport sink   (input valid, input mode, input task_index, output ready);
endinterface

`default_nettype wire

@@ rtl/btpq_rsp_if.sv @@
// response channel: status, popped entry and queue count
`timescale 1ns / 1ps
`default_nettype none

interface btpq_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [btpq_pkg::TASK_W-1:0] popped_task;
    logic [7:0] popped_priority;
    logic [3:0] queue_count;

    modport source (output valid, output status, output popped_task,
                    output popped_priority, output queue_count, input ready);
    modport sink   (input valid, input status, input popped_task,
                    input popped_priority, input queue_count, output ready);
endinterface

`default_nettype wire

@@ rtl/btpq_cell.sv @@
// one queue slot: load, shift toward head, odd-even compare-exchange
`timescale 1ns / 1ps
`default_nettype none

module btpq_cell #(
    parameter int QUEUE_DEPTH = 8,
    parameter int PRIO_W      = 8,
    parameter int IDX         = 0
) (
    input  wire                            i_clk,
    input  btpq_pkg::t_cell_cmd            i_cmd,
    input  wire [$clog2(QUEUE_DEPTH+1)-1:0] i_fill,
    input  wire [btpq_pkg::TASK_W-1:0]     i_new_task,
    input  wire [PRIO_W-1:0]               i_new_prio,
    input  wire [btpq_pkg::TASK_W-1:0]     i_left_task,
    input  wire [PRIO_W-1:0]               i_left_prio,
    input  wire [btpq_pkg::TASK_W-1:0]     i_right_task,
    input  wire [PRIO_W-1:0]               i_right_prio,
    output logic [btpq_pkg::TASK_W-1:0]    o_task,
    output logic [PRIO_W-1:0]              o_prio
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] MY_POS   = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] NEXT_POS = CNT_W'(IDX + 1);
    localparam bit HAS_LEFT  = (IDX > 0);
    localparam bit HAS_RIGHT = (IDX < QUEUE_DEPTH - 1);

    logic [btpq_pkg::TASK_W-1:0] r_task, n_task;
    logic [PRIO_W-1:0]           r_prio, n_prio;
    logic                        w_swap_right, w_swap_left;

    // both cells of a pair see the same compare, so they swap together
    always_comb begin
        w_swap_right = HAS_RIGHT && (MY_POS[0] == i_cmd.phase) && (NEXT_POS < i_fill)
                       && (i_right_prio < r_prio);
        w_swap_left  = HAS_LEFT && (MY_POS[0] != i_cmd.phase) && (MY_POS < i_fill)
                       && (r_prio < i_left_prio);
        n_task = r_task;
        n_prio = r_prio;
        case (i_cmd.op)
            btpq_pkg::CELL_LOAD: begin
                if (MY_POS == i_fill) begin
                    n_task = i_new_task;
                    n_prio = i_new_prio;
                end
            end
            btpq_pkg::CELL_SHIFT: begin
                if (HAS_RIGHT && (NEXT_POS < i_fill)) begin
                    n_task = i_right_task;
                    n_prio = i_right_prio;
                end
            end
            btpq_pkg::CELL_SORT: begin
                if (w_swap_right) begin
                    n_task = i_right_task;
                    n_prio = i_right_prio;
                end else if (w_swap_left) begin
                    n_task = i_left_task;
                    n_prio = i_left_prio;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_task <= n_task;
        r_prio <= n_prio;
    end

    assign o_task = r_task;
    assign o_prio = r_prio;

endmodule

`default_nettype wire

@@ rtl/bounded_task_priority_queue.sv @@
// add, pop and unused mode register their word in the cycle after acceptance
// sort registers its word after its last exchange phase in the sort state
// throughput: add and pop one word per cycle while the response is taken;
//   a sort holds off input, one odd-even exchange phase across the cell row each cycle
// reset: clears fill count, config registers, sort state and response valid;
//   slot contents are not cleared
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bounded_task_priority_queue #(
    parameter int QUEUE_DEPTH   = 8,
    parameter int PRIORITY_BITS = 8
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    btpq_cmd_if.sink                           i_cmd,
    btpq_rsp_if.source                         o_rsp,
    input  wire                                i_cfg_we,
    input  wire [btpq_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire [btpq_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // fill count holds 0..QUEUE_DEPTH
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    // one exchange phase per slot is enough to finish any fill level
    localparam int PASS_W = $clog2(QUEUE_DEPTH);
    // stored priority: masked copy of an 8 bit register
    localparam int PRIO_W = (PRIORITY_BITS < 8) ? PRIORITY_BITS : 8;
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(QUEUE_DEPTH);
    localparam logic [PASS_W-1:0] LAST_PASS = PASS_W'(QUEUE_DEPTH - 1);

    // controller states
    localparam logic S_IDLE = 1'b0;
    localparam logic S_SORT = 1'b1;

    localparam int TW = btpq_pkg::TASK_W;

    // configuration registers
    logic [2:0] r_task_count;
    logic [7:0] r_prio [btpq_pkg::NUM_TASKS];

    // control state
    logic              r_state, n_state;
    logic [PASS_W-1:0] r_pass, n_pass;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic              r_out_valid, n_out_valid;

    // response word
    logic [1:0]    r_status, n_status;
    logic [TW-1:0] r_ptask, n_ptask;
    logic [7:0]    r_pprio, n_pprio;
    logic [3:0]    r_count, n_count;

    // cell row
    logic [TW-1:0]     w_task [QUEUE_DEPTH];
    logic [PRIO_W-1:0] w_prio [QUEUE_DEPTH];
    btpq_pkg::t_cell_cmd w_cmd;

    logic          w_in_ready, w_accept, w_out_free;
    logic [2:0]    w_limit;
    logic [7:0]    w_sel_prio;
    logic [PRIO_W-1:0] w_new_prio;
    logic          w_is_add, w_is_sort, w_is_pop;
    logic          w_add_ok, w_pop_ok;

    // a finished word in the output register blocks acceptance until it is taken
    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_cmd.valid && w_in_ready;
    assign i_cmd.ready = w_in_ready;

    // task count beyond the register file saturates
    assign w_limit = (r_task_count > btpq_pkg::TASK_LIMIT) ? btpq_pkg::TASK_LIMIT
                                                          : r_task_count;
    assign w_sel_prio = (i_cmd.task_index < btpq_pkg::TASK_LIMIT)
                        ? r_prio[i_cmd.task_index] : 8'd0;
    assign w_new_prio = w_sel_prio[PRIO_W-1:0];

    assign w_is_add  = w_accept && (i_cmd.mode == btpq_pkg::MODE_ADD);
    assign w_is_sort = w_accept && (i_cmd.mode == btpq_pkg::MODE_SORT);
    assign w_is_pop  = w_accept && (i_cmd.mode == btpq_pkg::MODE_POP);
    assign w_add_ok  = w_is_add && (i_cmd.task_index < w_limit) && (r_fill != FULL_CNT);
    assign w_pop_ok  = w_is_pop && (r_fill != '0);

    // command broadcast to every cell
    always_comb begin
        w_cmd.phase = r_pass[0];
        if (r_state == S_SORT) begin
            w_cmd.op = btpq_pkg::CELL_SORT;
        end else if (w_add_ok) begin
            w_cmd.op = btpq_pkg::CELL_LOAD;
        end else if (w_pop_ok) begin
            w_cmd.op = btpq_pkg::CELL_SHIFT;
        end else begin
            w_cmd.op = btpq_pkg::CELL_HOLD;
        end
    end

    // slot 0 is the head; each cell sees both neighbors
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        localparam int LEFT  = (g == 0) ? 0 : g - 1;
        localparam int RIGHT = (g == QUEUE_DEPTH - 1) ? g : g + 1;
        btpq_cell #(
            .QUEUE_DEPTH (QUEUE_DEPTH),
            .PRIO_W      (PRIO_W),
            .IDX         (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_cmd        (w_cmd),
            .i_fill       (r_fill),
            .i_new_task   (i_cmd.task_index),
            .i_new_prio   (w_new_prio),
            .i_left_task  (w_task[LEFT]),
            .i_left_prio  (w_prio[LEFT]),
            .i_right_task (w_task[RIGHT]),
            .i_right_prio (w_prio[RIGHT]),
            .o_task       (w_task[g]),
            .o_prio       (w_prio[g])
        );
    end

    // controller and response word
    always_comb begin
        n_state     = r_state;
        n_pass      = r_pass;
        n_fill      = r_fill;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_status    = r_status;
        n_ptask     = r_ptask;
        n_pprio     = r_pprio;
        n_count     = r_count;
        unique case (r_state)
            S_IDLE: begin
                if (w_is_sort) begin
                    // result comes out after the last exchange phase
                    n_state = S_SORT;
                    n_pass  = '0;
                end else if (w_accept) begin
                    n_out_valid = 1'b1;
                    n_status    = btpq_pkg::ST_DONE;
                    n_ptask     = '0;
                    n_pprio     = '0;
                    if (w_is_add) begin
                        if (!(i_cmd.task_index < w_limit)) begin
                            n_status = btpq_pkg::ST_NO_TASK;
                        end else if (r_fill == FULL_CNT) begin
                            n_status = btpq_pkg::ST_FULL;
                        end else begin
                            n_fill = r_fill + 1'b1;
                        end
                    end else if (w_is_pop) begin
                        if (r_fill == '0) begin
                            n_status = btpq_pkg::ST_EMPTY;
                        end else begin
                            n_ptask = w_task[0];
                            n_pprio = 8'(w_prio[0]);
                            n_fill  = r_fill - 1'b1;
                        end
                    end
                    n_count = 4'(n_fill);
                end
            end
            S_SORT: begin
                n_pass = r_pass + 1'b1;
                if (r_pass == LAST_PASS) begin
                    // output register was freed when the sort was accepted
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_status    = btpq_pkg::ST_DONE;
                    n_ptask     = '0;
                    n_pprio     = '0;
                    n_count     = 4'(r_fill);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pass      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pass      <= n_pass;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_ptask  <= n_ptask;
        r_pprio  <= n_pprio;
        r_count  <= n_count;
    end

    // config writes: task count, then one priority per task
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_count <= '0;
            for (int k = 0; k < btpq_pkg::NUM_TASKS; k++) begin
                r_prio[k] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == btpq_pkg::CFG_TASK_COUNT) begin
                r_task_count <= i_cfg_data[2:0];
            end else if ((i_cfg_idx >= btpq_pkg::CFG_PRIO_FIRST)
                         && (i_cfg_idx <= btpq_pkg::CFG_PRIO_LAST)) begin
                r_prio[3'(i_cfg_idx - btpq_pkg::CFG_PRIO_FIRST)] <= i_cfg_data;
            end
        end
    end

    // response port
    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_status;
    assign o_rsp.popped_task     = r_ptask;
    assign o_rsp.popped_priority = r_pprio;
    assign o_rsp.queue_count     = r_count;

    // fill level never passes the slot count
    `ASSERT_NEVER(a_fill_bound, r_fill > FULL_CNT, "fill count beyond queue depth")
    // the entry count is frozen while the cells exchange
    `ASSERT_CLK(a_sort_fill_stable, (r_state == S_SORT) |=> (r_fill == $past(r_fill)), "fill changed during sort")
    // the last exchange phase always hands a word to the output
    `ASSERT_CLK(a_sort_done_word, (r_state == S_SORT && r_pass == LAST_PASS) |=> (r_out_valid && r_state == S_IDLE), "sort ended without response")
    // an empty status only ever reports an empty queue
    `ASSERT_CLK(a_empty_count, (r_out_valid && r_status == btpq_pkg::ST_EMPTY) |-> (r_count == 4'd0), "empty status with entries held")

endmodule

`default_nettype wire
